### rtl/core/pmrt_pkg.sv
// ----------------------------------------------------------------------------
// pmrt_pkg
// Shared sizes, codes and field widths of the prompt mark row tracker.
// ----------------------------------------------------------------------------
package pmrt_pkg;

    localparam int DEPTH    = 256;
    localparam int ROW_BITS = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int EXIT_W   = 9;
    localparam int DELTA_W  = 17;
    localparam int FOUND_W  = ROW_BITS + 1;
    localparam int SUM_W    = ((ROW_BITS + 1 > DELTA_W) ? ROW_BITS + 1 : DELTA_W) + 1;
    localparam int ENTRY_W  = ROW_BITS + EXIT_W;

    localparam logic [ROW_BITS-1:0] ROW_MAX      = {ROW_BITS{1'b1}};
    localparam logic [EXIT_W-1:0]   EXIT_UNKNOWN = {EXIT_W{1'b1}};
    localparam logic [FOUND_W-1:0]  ROW_NONE     = {FOUND_W{1'b1}};

    localparam logic [1:0] MODE_MARK   = 2'd0;
    localparam logic [1:0] MODE_PREV   = 2'd1;
    localparam logic [1:0] MODE_NEXT   = 2'd2;
    localparam logic [1:0] MODE_SCROLL = 2'd3;

    localparam logic [7:0] KIND_A = 8'h41;
    localparam logic [7:0] KIND_B = 8'h42;
    localparam logic [7:0] KIND_C = 8'h43;
    localparam logic [7:0] KIND_D = 8'h44;

endpackage

### rtl/core/prompt_mark_row_tracker_core.sv
// ----------------------------------------------------------------------------
// prompt_mark_row_tracker_core
// Rolling window of prompt rows with exit codes, nearest-row queries and scroll.
// ----------------------------------------------------------------------------
// Each transfer in gives exactly one transfer out. A mark item passes
// through the ST_MARK and ST_RESP states before its result is loaded. A
// query or scroll item walks the stored entries through the single read
// port of the entry RAM, one entry per cycle, in ST_SCAN, then loads its
// result from ST_RESP. Scroll writes the compacted entries back through the
// write port in the same pass. A new item is accepted once the previous
// result has been loaded into the output register, even while that result
// still waits.
module prompt_mark_row_tracker_core
    import pmrt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 mode,
    input  logic [7:0]                 kind_byte,
    input  logic [ROW_BITS-1:0]        row,
    input  logic signed [DELTA_W-1:0]  delta,
    input  logic                       exit_valid,
    input  logic [7:0]                 exit_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       status,
    output logic signed [FOUND_W-1:0]  found_row,
    output logic [CNT_W-1:0]           mark_count,
    output logic signed [FOUND_W-1:0]  last_row,
    output logic signed [EXIT_W-1:0]   last_exit
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t                state_reg;
    logic [1:0]            mode_reg;
    logic [7:0]            kind_reg;
    logic [ROW_BITS-1:0]   row_reg;
    logic [DELTA_W-1:0]    delta_reg;
    logic                  ev_reg;
    logic [7:0]            evalue_reg;
    logic [IDX_W-1:0]      oldest_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [EXIT_W-1:0]     pending_reg;
    logic [ROW_BITS-1:0]   last_row_reg;
    logic [EXIT_W-1:0]     last_exit_reg;
    logic [CNT_W-1:0]      i_reg;
    logic [CNT_W-1:0]      w_reg;
    logic                  rd_valid_reg;
    logic                  fv_reg;
    logic [ROW_BITS-1:0]   found_reg;
    logic                  status_reg;
    logic                  out_valid_reg;
    logic                  out_status_reg;
    logic [FOUND_W-1:0]    out_found_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic [FOUND_W-1:0]    out_last_row_reg;
    logic [EXIT_W-1:0]     out_last_exit_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [ROW_BITS-1:0]   rd_row;
    logic [EXIT_W-1:0]     rd_exit;
    logic signed [SUM_W-1:0] scroll_sum;
    logic                  keep;
    logic [ROW_BITS-1:0]   clamped;
    logic [IDX_W-1:0]      mark_slot;
    logic                  kind_ok;
    logic                  in_take;
    logic                  out_free;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign rd_row  = ram_rdata[ENTRY_W-1:EXIT_W];
    assign rd_exit = ram_rdata[EXIT_W-1:0];

    always_comb
    begin
        kind_ok    = (kind_reg inside {KIND_A, KIND_B, KIND_C, KIND_D});
        scroll_sum = $signed({{(SUM_W - ROW_BITS){1'b0}}, rd_row})
                   + $signed({{(SUM_W - DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg});
        keep       = !scroll_sum[SUM_W-1];
        if (scroll_sum[SUM_W-2:ROW_BITS] != '0)
        begin
            clamped = ROW_MAX;
        end
        else
        begin
            clamped = scroll_sum[ROW_BITS-1:0];
        end
        if (count_reg < CNT_W'(DEPTH))
        begin
            mark_slot = slot_of(oldest_reg, count_reg);
        end
        else
        begin
            mark_slot = oldest_reg;
        end
        ram_re    = (state_reg == ST_SCAN) && (i_reg < count_reg);
        ram_raddr = slot_of(oldest_reg, i_reg);
        ram_we    = 1'b0;
        ram_waddr = mark_slot;
        ram_wdata = {row_reg, pending_reg};
        if (state_reg == ST_MARK && kind_reg == KIND_A)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_SCAN && rd_valid_reg && mode_reg == MODE_SCROLL && keep)
        begin
            ram_we    = 1'b1;
            ram_waddr = slot_of(oldest_reg, w_reg);
            ram_wdata = {clamped, rd_exit};
        end
    end

    pmrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            oldest_reg        <= '0;
            count_reg         <= '0;
            pending_reg       <= EXIT_UNKNOWN;
            i_reg             <= '0;
            w_reg             <= '0;
            rd_valid_reg      <= 1'b0;
            fv_reg            <= 1'b0;
            out_valid_reg     <= 1'b0;
            mode_reg          <= MODE_MARK;
            kind_reg          <= '0;
            row_reg           <= '0;
            delta_reg         <= '0;
            ev_reg            <= 1'b0;
            evalue_reg        <= '0;
            last_row_reg      <= '0;
            last_exit_reg     <= EXIT_UNKNOWN;
            found_reg         <= '0;
            status_reg        <= 1'b0;
            out_status_reg    <= 1'b0;
            out_found_reg     <= ROW_NONE;
            out_count_reg     <= '0;
            out_last_row_reg  <= ROW_NONE;
            out_last_exit_reg <= EXIT_UNKNOWN;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_RESP)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_valid_reg <= ram_re;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        mode_reg   <= mode;
                        kind_reg   <= kind_byte;
                        row_reg    <= row;
                        delta_reg  <= delta;
                        ev_reg     <= exit_valid;
                        evalue_reg <= exit_value;
                        i_reg      <= '0;
                        w_reg      <= '0;
                        fv_reg     <= 1'b0;
                        status_reg <= 1'b0;
                        if (mode == MODE_MARK)
                        begin
                            state_reg <= ST_MARK;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_MARK:
                begin
                    state_reg <= ST_RESP;
                    if (kind_reg == KIND_A)
                    begin
                        if (count_reg < CNT_W'(DEPTH))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            oldest_reg <= slot_of(oldest_reg, CNT_W'(1));
                        end
                        last_row_reg  <= row_reg;
                        last_exit_reg <= pending_reg;
                        pending_reg   <= EXIT_UNKNOWN;
                    end
                    else if (kind_reg == KIND_D)
                    begin
                        pending_reg <= ev_reg ? {1'b0, evalue_reg} : EXIT_UNKNOWN;
                    end
                    else if (!kind_ok)
                    begin
                        status_reg <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (ram_re)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    if (rd_valid_reg)
                    begin
                        case (mode_reg)
                            MODE_PREV:
                            begin
                                if (rd_row < row_reg && (!fv_reg || rd_row > found_reg))
                                begin
                                    fv_reg    <= 1'b1;
                                    found_reg <= rd_row;
                                end
                            end
                            MODE_NEXT:
                            begin
                                if (rd_row > row_reg && (!fv_reg || rd_row < found_reg))
                                begin
                                    fv_reg    <= 1'b1;
                                    found_reg <= rd_row;
                                end
                            end
                            MODE_SCROLL:
                            begin
                                if (keep)
                                begin
                                    w_reg         <= w_reg + 1'b1;
                                    last_row_reg  <= clamped;
                                    last_exit_reg <= rd_exit;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    if (!ram_re && !rd_valid_reg)
                    begin
                        state_reg <= ST_RESP;
                        if (mode_reg == MODE_SCROLL)
                        begin
                            count_reg <= w_reg;
                        end
                    end
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_found_reg  <= fv_reg ? {1'b0, found_reg} : ROW_NONE;
                        out_count_reg  <= count_reg;
                        if (count_reg != '0)
                        begin
                            out_last_row_reg  <= {1'b0, last_row_reg};
                            out_last_exit_reg <= last_exit_reg;
                        end
                        else
                        begin
                            out_last_row_reg  <= ROW_NONE;
                            out_last_exit_reg <= EXIT_UNKNOWN;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found_row  = $signed(out_found_reg);
    assign mark_count = out_count_reg;
    assign last_row   = $signed(out_last_row_reg);
    assign last_exit  = $signed(out_last_exit_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the window depth");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> state_reg == ST_SCAN)
        else $error("read data returned outside a scan");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> w_reg <= i_reg)
        else $error("compaction write index ran ahead of the read index");

    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> ram_waddr != ram_raddr)
        else $error("scroll write hit an entry that is still to be read");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg != ST_IDLE)
        else $error("accepted transfer did not start processing");
`endif

endmodule

### rtl/core/pmrt_ram.sv
// ----------------------------------------------------------------------------
// pmrt_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
